// File: src/spmd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spmd_pkg
// Shared types and constants of the signal pending mask dispatch block.
// ----------------------------------------------------------------------------
package spmd_pkg;

    // Operation codes of an input transaction.
    localparam logic [2:0] FUNC_SEND      = 3'd0;
    localparam logic [2:0] FUNC_SETACTION = 3'd1;
    localparam logic [2:0] FUNC_PROCMASK  = 3'd2;
    localparam logic [2:0] FUNC_DELIVER   = 3'd3;
    localparam logic [2:0] FUNC_SIGRETURN = 3'd4;

    // Mask modes of procmask.
    localparam logic [1:0] HOW_BLOCK   = 2'd0;
    localparam logic [1:0] HOW_UNBLOCK = 2'd1;
    localparam logic [1:0] HOW_SET     = 2'd2;

    // Result actions.
    localparam logic [1:0] ACT_CONTINUE  = 2'd0;
    localparam logic [1:0] ACT_TERMINATE = 2'd1;
    localparam logic [1:0] ACT_HANDLER   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_KILL     = 3'd0;
    localparam logic [2:0] CFG_STOP     = 3'd1;
    localparam logic [2:0] CFG_CHILD    = 3'd2;
    localparam logic [2:0] CFG_CONT     = 3'd3;
    localparam logic [2:0] CFG_DEFAULT  = 3'd4;
    localparam logic [2:0] CFG_IGNORE   = 3'd5;
    localparam logic [2:0] CFG_MAGIC    = 3'd6;

    localparam logic [63:0] QUERY_CODE     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] RED_ZONE       = 64'd128;
    localparam logic [63:0] ALIGN_MASK     = ~64'd15;
    localparam logic [7:0]  EXIT_BASE      = 8'd128;
    localparam logic [7:0]  BAD_FRAME_EXIT = 8'd139;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_READ,
        ST_JUDGE,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input transaction
        logic exec;      // run a single-step operation
        logic scan;      // compute the lowest deliverable signal
        logic rd;        // read the action entry of the chosen signal
        logic judge;     // decide on the entry just read
        logic clr_out;   // clear result before a new transaction
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_deliver;
        logic none_left;  // no deliverable signal remains
        logic skip;       // entry was ignored, look again
    } t_stat;

endpackage
`default_nettype wire

// File: src/signal_pending_mask_dispatch_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// signal_pending_mask_dispatch_top
// Signal state of one task: pending and blocked masks, action table, delivery.
// ----------------------------------------------------------------------------
// Each transaction is handled one at a time. Send, set_action, procmask,
// sigreturn and a deliver outside user mode pass through the accepting
// state, one execute state and the state in which the result is offered.
// A deliver in user mode adds a scan, read and decide pass for each pending
// signal examined, plus one more scan when it ends because no deliverable
// signal is left: the controller visits each candidate with one read of the
// action table, so every ignored signal that is skipped adds one scan, read
// and decide pass. A new transaction is taken after the result is accepted.
module signal_pending_mask_dispatch_top #(
    parameter int NUM_SIGNALS = 32,
    parameter int FRAME_BYTES = 192
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [2:0]  i_func,
    input  wire  [5:0]  i_signal_num,
    input  wire  [63:0] i_value,
    input  wire  [63:0] i_restorer_addr,
    input  wire  [1:0]  i_mask_how,
    input  wire         i_user_mode,
    input  wire         i_target_waiting,
    input  wire         i_target_running,
    input  wire  [63:0] i_frame_magic,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic        o_status,
    output logic [1:0]  o_action,
    output logic [5:0]  o_chosen_signal,
    output logic [7:0]  o_exit_code,
    output logic [63:0] o_handler_addr,
    output logic [63:0] o_return_addr,
    output logic [63:0] o_saved_mask,
    output logic [63:0] o_frame_addr,
    output logic [63:0] o_new_stack,
    output logic [63:0] o_old_value,
    output logic        o_wake
);
    import spmd_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer.
    spmd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_stat(stat), .o_cmd(cmd)
    );

    // Datapath.
    spmd_dp #(.NUM_SIGNALS(NUM_SIGNALS), .FRAME_BYTES(FRAME_BYTES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_func(i_func), .i_signal_num(i_signal_num), .i_value(i_value),
        .i_restorer_addr(i_restorer_addr), .i_mask_how(i_mask_how),
        .i_user_mode(i_user_mode), .i_target_waiting(i_target_waiting),
        .i_target_running(i_target_running), .i_frame_magic(i_frame_magic),
        .i_cmd(cmd), .o_stat(stat),
        .o_status(o_status), .o_action(o_action),
        .o_chosen_signal(o_chosen_signal), .o_exit_code(o_exit_code),
        .o_handler_addr(o_handler_addr), .o_return_addr(o_return_addr),
        .o_saved_mask(o_saved_mask), .o_frame_addr(o_frame_addr),
        .o_new_stack(o_new_stack), .o_old_value(o_old_value), .o_wake(o_wake)
    );
endmodule
`default_nettype wire

// File: src/spmd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spmd_ctrl
// Controller state machine that sequences each transaction.
// ----------------------------------------------------------------------------
module spmd_ctrl (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  wire  i_out_ready,
    input  wire  spmd_pkg::t_stat i_stat,
    output spmd_pkg::t_cmd o_cmd
);
    import spmd_pkg::*;

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_EXEC;
            ST_EXEC:  n_state = i_stat.is_deliver ? ST_SCAN : ST_OUT;
            ST_SCAN:  n_state = i_stat.none_left ? ST_OUT : ST_READ;
            ST_READ:  n_state = ST_JUDGE;
            ST_JUDGE: n_state = i_stat.skip ? ST_SCAN : ST_OUT;
            ST_OUT:   if (i_out_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load    = i_in_valid;
                o_cmd.clr_out = i_in_valid;
            end
            ST_EXEC:  o_cmd.exec  = 1'b1;
            ST_SCAN:  o_cmd.scan  = 1'b1;
            ST_READ:  o_cmd.rd    = 1'b1;
            ST_JUDGE: o_cmd.judge = 1'b1;
            ST_OUT:   o_out_valid = 1'b1;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// File: src/spmd_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spmd_dp
// Datapath: masks, action table memory, configuration and result registers.
// ----------------------------------------------------------------------------
module spmd_dp #(
    parameter int NUM_SIGNALS = 32,
    parameter int FRAME_BYTES = 192
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data,
    input  wire  [2:0]  i_func,
    input  wire  [5:0]  i_signal_num,
    input  wire  [63:0] i_value,
    input  wire  [63:0] i_restorer_addr,
    input  wire  [1:0]  i_mask_how,
    input  wire         i_user_mode,
    input  wire         i_target_waiting,
    input  wire         i_target_running,
    input  wire  [63:0] i_frame_magic,
    input  wire  spmd_pkg::t_cmd i_cmd,
    output spmd_pkg::t_stat o_stat,
    output logic        o_status,
    output logic [1:0]  o_action,
    output logic [5:0]  o_chosen_signal,
    output logic [7:0]  o_exit_code,
    output logic [63:0] o_handler_addr,
    output logic [63:0] o_return_addr,
    output logic [63:0] o_saved_mask,
    output logic [63:0] o_frame_addr,
    output logic [63:0] o_new_stack,
    output logic [63:0] o_old_value,
    output logic        o_wake
);
    import spmd_pkg::*;

    localparam int NS = NUM_SIGNALS;
    localparam int AW = (NS > 1) ? $clog2(NS) : 1;
    localparam logic [63:0] FRAME = 64'(FRAME_BYTES);

    // Configuration.
    logic [5:0]  r_kill, r_stop, r_child, r_cont;
    logic [63:0] r_dflt, r_ign, r_magic;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kill <= 6'd9; r_stop <= 6'd19; r_child <= 6'd17; r_cont <= 6'd18;
            r_dflt <= 64'd0; r_ign <= 64'd1; r_magic <= 64'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KILL:    r_kill  <= i_cfg_data[5:0];
                CFG_STOP:    r_stop  <= i_cfg_data[5:0];
                CFG_CHILD:   r_child <= i_cfg_data[5:0];
                CFG_CONT:    r_cont  <= i_cfg_data[5:0];
                CFG_DEFAULT: r_dflt  <= i_cfg_data;
                CFG_IGNORE:  r_ign   <= i_cfg_data;
                CFG_MAGIC:   r_magic <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Captured input transaction.
    logic [2:0]  r_func;
    logic [5:0]  r_sig;
    logic [63:0] r_val, r_rest, r_fmag;
    logic [1:0]  r_how;
    logic        r_user, r_wait, r_run;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func; r_sig <= i_signal_num; r_val <= i_value;
            r_rest <= i_restorer_addr; r_how <= i_mask_how; r_user <= i_user_mode;
            r_wait <= i_target_waiting; r_run <= i_target_running;
            r_fmag <= i_frame_magic;
        end
    end

    function automatic logic [NS-1:0] bit_of(input logic [5:0] s);
        logic [NS-1:0] b;
        b = '0;
        if (32'(s) < NS) b[s[AW-1:0]] = 1'b1;
        return b;
    endfunction

    logic [NS-1:0] r_pend, r_blk;
    logic [63:0]   r_tramp;
    logic [NS-1:0] prot, sigbit, dmask;
    logic [NS-1:0] valn;
    assign prot   = bit_of(r_kill) | bit_of(r_stop);
    assign sigbit = bit_of(r_sig);
    assign valn   = r_val[NS-1:0];

    // Lowest deliverable signal.
    logic [AW-1:0] low_s;
    always_comb begin
        dmask = r_pend & ~r_blk;
        dmask[0] = 1'b0;
        low_s = '0;
        for (int k = NS - 1; k >= 1; k--) begin
            if (dmask[k]) low_s = AW'(k);
        end
    end

    // Action table; the valid bits stand in for the reset of every entry to the
    // default code as it stands at reset, which is zero.
    logic [63:0]   mem [NS];
    logic [NS-1:0] r_tvalid;
    logic [63:0]   r_rdata;
    logic          r_rvalid;
    logic [AW-1:0] r_cur;
    logic [63:0]   entry;
    logic          tbl_we;
    assign entry  = r_rvalid ? r_rdata : 64'd0;
    assign tbl_we = i_cmd.exec && r_func == FUNC_SETACTION && r_sig != 6'd0 &&
                    32'(r_sig) < NS && r_val != QUERY_CODE &&
                    r_sig != r_kill && r_sig != r_stop;

    always_ff @(posedge i_clk) begin
        if (tbl_we) mem[r_sig[AW-1:0]] <= r_val;
        if (i_cmd.exec) r_rdata <= mem[r_sig[AW-1:0]];
        else if (i_cmd.rd) r_rdata <= mem[r_cur];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= '0;
        end else if (tbl_we) begin
            r_tvalid[r_sig[AW-1:0]] <= 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) r_rvalid <= r_tvalid[r_sig[AW-1:0]];
        else if (i_cmd.rd) r_rvalid <= r_tvalid[r_cur];
        if (i_cmd.scan) r_cur <= low_s;
    end

    // Frame layout.
    logic [63:0] sp0, sp1;
    assign sp0 = (r_val - RED_ZONE) & ALIGN_MASK;
    assign sp1 = (sp0 - FRAME) & ALIGN_MASK;

    logic [5:0] cur6;
    assign cur6 = 6'(r_cur);
    logic dflt_ign;
    assign dflt_ign = cur6 == r_child || cur6 == r_cont || cur6 == r_stop;

    assign o_stat.is_deliver = r_func == FUNC_DELIVER && r_user;
    assign o_stat.none_left  = dmask == '0;
    assign o_stat.skip       = entry == r_ign || (entry == r_dflt && dflt_ign);

    // State and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0; r_blk <= '0; r_tramp <= '0;
        end else begin
            if (i_cmd.exec) begin
                case (r_func)
                    FUNC_SEND: r_pend <= r_pend | sigbit;
                    FUNC_SETACTION: if (tbl_we && r_rest != 64'd0) r_tramp <= r_rest;
                    FUNC_PROCMASK: begin
                        case (r_how)
                            HOW_BLOCK:   r_blk <= (r_blk | valn) & ~prot;
                            HOW_UNBLOCK: r_blk <= (r_blk & ~valn) & ~prot;
                            HOW_SET:     r_blk <= valn & ~prot;
                            default:     r_blk <= r_blk & ~prot;
                        endcase
                    end
                    FUNC_SIGRETURN: if (r_fmag == r_magic) r_blk <= valn & ~prot;
                    default: ;
                endcase
            end
            if (i_cmd.rd) r_pend[r_cur] <= 1'b0;
            if (i_cmd.judge && !o_stat.skip && entry != r_dflt && r_tramp != 64'd0)
                r_blk[r_cur] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_out) begin
            o_status <= 1'b0; o_action <= ACT_CONTINUE; o_chosen_signal <= '0;
            o_exit_code <= '0; o_handler_addr <= '0; o_return_addr <= '0;
            o_saved_mask <= '0; o_frame_addr <= '0; o_new_stack <= '0;
            o_old_value <= '0; o_wake <= 1'b0;
        end
        if (i_cmd.exec) begin
            case (r_func)
                FUNC_SEND: begin
                    o_status <= !(32'(r_sig) < NS);
                    o_wake <= r_sig != 6'd0 && 32'(r_sig) < NS && r_wait &&
                              !(|(r_blk & sigbit)) && !r_run;
                end
                FUNC_SETACTION: begin
                    if (r_sig == 6'd0 || !(32'(r_sig) < NS)) begin
                        o_status <= 1'b1;
                    end else begin
                        o_old_value <= r_tvalid[r_sig[AW-1:0]] ?
                                       mem[r_sig[AW-1:0]] : 64'd0;
                        o_status <= r_val != QUERY_CODE &&
                                    (r_sig == r_kill || r_sig == r_stop);
                    end
                end
                FUNC_PROCMASK: o_old_value <= 64'(r_blk);
                FUNC_DELIVER: ;
                FUNC_SIGRETURN: begin
                    o_old_value <= 64'(r_blk);
                    if (r_fmag != r_magic) begin
                        o_action <= ACT_TERMINATE;
                        o_exit_code <= BAD_FRAME_EXIT;
                    end
                end
                default: o_status <= 1'b1;
            endcase
        end
        if (i_cmd.judge && !o_stat.skip) begin
            o_chosen_signal <= cur6;
            if (entry == r_dflt || r_tramp == 64'd0) begin
                o_action <= ACT_TERMINATE;
                o_exit_code <= EXIT_BASE + {2'b00, cur6};
            end else begin
                o_action <= ACT_HANDLER;
                o_handler_addr <= entry;
                o_return_addr <= r_tramp;
                o_saved_mask <= 64'(r_blk);
                o_frame_addr <= sp1;
                o_new_stack <= sp1 - 64'd8;
            end
        end
    end
endmodule
`default_nettype wire
